@@ hw/rtl/bresenham_line_stepper_top_macros.svh @@
// Assertion macros of the line stepper RTL.
`ifndef BRESENHAM_LINE_STEPPER_TOP_MACROS_SVH
`define BRESENHAM_LINE_STEPPER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define BLS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("line stepper assertion failed");
`define BLS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("line stepper assertion failed");
`define BLS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("line stepper assertion failed");
`else
`define BLS_ASSERT(lbl, prop)
`define BLS_ASSERT_IMP(lbl, ante, cons)
`define BLS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ hw/rtl/bls_pkg.sv @@
// Types and constants of the line stepper.
package bls_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned DiffW  = CoordW + 1;
  localparam int unsigned ErrW   = CoordW + 4;
  localparam int unsigned ColorW = 32;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [DiffW-1:0]  diff_t;
  typedef logic signed [ErrW-1:0]   err_t;
  typedef logic [ColorW-1:0]        color_t;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_STEP = 1'b1
  } req_e;

  typedef struct packed {
    req_e   req_type;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    color_t line_color;
  } bls_in_t;

  typedef struct packed {
    logic   pixel_valid;
    coord_t pixel_x;
    coord_t pixel_y;
    color_t pixel_color;
    logic   last_pixel;
  } bls_out_t;

  // Captured item together with its end-point differences.
  typedef struct packed {
    bls_in_t item;
    diff_t   dx;
    diff_t   dy;
  } bls_stage_t;

endpackage

@@ hw/rtl/bls_in_reg.sv @@
// Input register of the line stepper with end-point difference precompute.
module bls_in_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bls_pkg::bls_in_t    in_data_i,
  input  logic                advance_i,
  output logic                stage_valid_o,
  output bls_pkg::bls_stage_t stage_data_o
);
  import bls_pkg::*;

  logic       valid_q, valid_d;
  logic       accept;
  bls_stage_t data_q, data_d;

  assign in_stall_o = valid_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    data_d.item = in_data_i;
    data_d.dx   = diff_t'(in_data_i.end_x) - diff_t'(in_data_i.start_x);
    data_d.dy   = diff_t'(in_data_i.end_y) - diff_t'(in_data_i.start_y);
  end

  always_comb begin
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= data_d;
    end
  end

  assign stage_valid_o = valid_q;
  assign stage_data_o  = data_q;

endmodule

@@ hw/rtl/bls_step_core.sv @@
// Line setup, Bresenham stepping state and the result register.
`include "bresenham_line_stepper_top_macros.svh"

module bls_step_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                stage_valid_i,
  input  bls_pkg::bls_stage_t stage_data_i,
  output logic                advance_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bls_pkg::bls_out_t   out_data_o
);
  import bls_pkg::*;

  // Stepping state.
  logic   active_q, active_d;
  coord_t cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  coord_t major_end_q, major_end_d;
  err_t   err_q, err_d, inc_s_q, inc_s_d, inc_d_q, inc_d_d;
  logic   y_major_q, y_major_d, minor_neg_q, minor_neg_d, axis_q, axis_d;
  color_t color_q, color_d;

  // Result register.
  logic     out_valid_q;
  bls_out_t out_q, out_d;

  logic fire;
  logic idle_step;

  // Load setup terms.
  bls_in_t item;
  diff_t   dx, dy, abs_dx, abs_dy, amaj, amin;
  logic    ld_axis, ld_ymaj, ld_swap;
  coord_t  ld_x, ld_y, ld_major;
  err_t    two_amin;

  // Step terms.
  logic   move_minor;
  coord_t cur_major;
  coord_t major_n;

  assign advance_o = !out_valid_q || !out_stall_i;
  assign fire      = advance_o && stage_valid_i;
  assign idle_step = fire && (item.req_type == REQ_STEP) && !active_q;

  assign item   = stage_data_i.item;
  assign dx     = stage_data_i.dx;
  assign dy     = stage_data_i.dy;
  assign abs_dx = dx[DiffW-1] ? -dx : dx;
  assign abs_dy = dy[DiffW-1] ? -dy : dy;

  // Lines are walked from the end with the smaller major coordinate; the
  // axis-aligned cases fall into the same selection.
  assign ld_axis  = (dx == '0) || (dy == '0);
  assign ld_ymaj  = ld_axis ? (dx == '0) : !(abs_dy < abs_dx);
  assign ld_swap  = ld_ymaj ? dy[DiffW-1] : dx[DiffW-1];
  assign ld_x     = ld_swap ? item.end_x : item.start_x;
  assign ld_y     = ld_swap ? item.end_y : item.start_y;
  assign ld_major = ld_ymaj ? (ld_swap ? item.start_y : item.end_y)
                            : (ld_swap ? item.start_x : item.end_x);
  assign amaj     = ld_ymaj ? abs_dy : abs_dx;
  assign amin     = ld_ymaj ? abs_dx : abs_dy;
  assign two_amin = err_t'(amin) <<< 1;

  assign cur_major  = y_major_q ? cur_y_q : cur_x_q;
  assign move_minor = !axis_q && (err_q > err_t'(0));
  assign major_n    = cur_major + coord_t'(1);

  always_comb begin
    active_d    = active_q;
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    major_end_d = major_end_q;
    err_d       = err_q;
    inc_s_d     = inc_s_q;
    inc_d_d     = inc_d_q;
    y_major_d   = y_major_q;
    minor_neg_d = minor_neg_q;
    axis_d      = axis_q;
    color_d     = color_q;
    out_d       = '0;

    if (item.req_type == REQ_LOAD) begin
      cur_x_d     = ld_x;
      cur_y_d     = ld_y;
      major_end_d = ld_major;
      y_major_d   = ld_ymaj;
      axis_d      = ld_axis;
      color_d     = item.line_color;
      if (ld_axis) begin
        err_d       = '0;
        inc_s_d     = '0;
        inc_d_d     = '0;
        minor_neg_d = 1'b0;
      end else begin
        inc_s_d     = two_amin;
        inc_d_d     = two_amin - (err_t'(amaj) <<< 1);
        err_d       = two_amin - err_t'(amaj);
        // The minor direction flips when the walk starts from the far end.
        minor_neg_d = ld_ymaj ? (ld_swap ? (dx > diff_t'(0)) : dx[DiffW-1])
                              : (ld_swap ? (dy > diff_t'(0)) : dy[DiffW-1]);
      end
      active_d          = ((ld_ymaj ? ld_y : ld_x) != ld_major);
      out_d.pixel_valid = 1'b1;
      out_d.pixel_x     = ld_x;
      out_d.pixel_y     = ld_y;
      out_d.pixel_color = item.line_color;
      out_d.last_pixel  = !active_d;
    end else if (active_q) begin
      if (!axis_q) begin
        err_d = err_q + (move_minor ? inc_d_q : inc_s_q);
      end
      if (y_major_q) begin
        cur_y_d = major_n;
        if (move_minor) begin
          cur_x_d = minor_neg_q ? cur_x_q - coord_t'(1) : cur_x_q + coord_t'(1);
        end
      end else begin
        cur_x_d = major_n;
        if (move_minor) begin
          cur_y_d = minor_neg_q ? cur_y_q - coord_t'(1) : cur_y_q + coord_t'(1);
        end
      end
      active_d          = !(major_n >= major_end_q);
      out_d.pixel_valid = 1'b1;
      out_d.pixel_x     = cur_x_d;
      out_d.pixel_y     = cur_y_d;
      out_d.pixel_color = color_q;
      out_d.last_pixel  = !active_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      major_end_q <= '0;
      err_q       <= '0;
      inc_s_q     <= '0;
      inc_d_q     <= '0;
      y_major_q   <= 1'b0;
      minor_neg_q <= 1'b0;
      axis_q      <= 1'b0;
      color_q     <= '0;
    end else begin
      if (fire) begin
        active_q    <= active_d;
        cur_x_q     <= cur_x_d;
        cur_y_q     <= cur_y_d;
        major_end_q <= major_end_d;
        err_q       <= err_d;
        inc_s_q     <= inc_s_d;
        inc_d_q     <= inc_d_d;
        y_major_q   <= y_major_d;
        minor_neg_q <= minor_neg_d;
        axis_q      <= axis_d;
        color_q     <= color_d;
      end
      if (advance_o) begin
        out_valid_q <= stage_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `BLS_ASSERT_IMP(a_active_before_end, active_q, cur_major < major_end_q)
  `BLS_ASSERT_IMP(a_axis_err_zero, active_q && axis_q, err_q == '0)
  `BLS_ASSERT_NEXT(a_idle_step_empty, idle_step, !out_q.pixel_valid)
  `BLS_ASSERT_NEXT(a_hold_on_stall, !advance_o, $stable(active_q) && $stable(cur_x_q) && $stable(cur_y_q))

endmodule

@@ hw/rtl/bresenham_line_stepper_top.sv @@
// Bresenham line stepper: one result per load or step transfer (no pixel if idle).
// Each item passes through the input register and then the result register.
// Throughput: one item per cycle while the result side does not stall;
// setup and each step are combinational logic ahead of the result register.
// Stalls on the result side hold the input register and the stepping state.
// Reset (asynchronous, active low) clears the pipeline valids and the line state.
module bresenham_line_stepper_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bls_pkg::bls_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output bls_pkg::bls_out_t out_data_o
);
  import bls_pkg::*;

  logic       advance;
  logic       stage_valid;
  bls_stage_t stage_data;

  bls_in_reg u_in_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_data_i     (in_data_i),
    .advance_i     (advance),
    .stage_valid_o (stage_valid),
    .stage_data_o  (stage_data)
  );

  bls_step_core u_step_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stage_valid_i (stage_valid),
    .stage_data_i  (stage_data),
    .advance_o     (advance),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_o    (out_data_o)
  );

endmodule
